/* sv/tcsve_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcsve_pkg
// Types, constants and lookup functions for the text cell to VRAM encoder.
// ----------------------------------------------------------------------------
package tcsve_pkg;

  localparam int ADDR_W = 11;
  localparam int COLS_W = 7;
  localparam int ROW_W  = 5;
  localparam int FG_W   = 3;

  localparam logic [COLS_W-1:0] COLS_RESET = 7'd80;

  localparam logic [7:0] LEAD_A_LO = 8'h81;
  localparam logic [7:0] LEAD_A_HI = 8'h9f;
  localparam logic [7:0] LEAD_B_LO = 8'he0;
  localparam logic [7:0] LEAD_B_HI = 8'hfc;
  localparam logic [7:0] SPECIAL_LIMIT = 8'h1c;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RIGHT_HALF = 8'h80;

  // source cell held in the input register
  typedef struct packed {
    logic [7:0]        char_byte;
    logic [FG_W-1:0]   fg;
    logic [ROW_W-1:0]  row_index;
    logic [COLS_W-1:0] column_index;
    logic              span_end;
  } cell_t;

  // one VRAM write
  typedef struct packed {
    logic [ADDR_W-1:0] cell_address;
    logic [15:0]       char_word;
    logic [7:0]        attr_byte;
    logic              last_write;
  } wr_t;

  function automatic logic [7:0] fg_attr(input logic [FG_W-1:0] fg);
    logic [7:0] a;
    case (fg)
      3'd0:    a = 8'h01;
      3'd1:    a = 8'h21;
      3'd2:    a = 8'h81;
      3'd3:    a = 8'ha1;
      3'd4:    a = 8'h41;
      3'd5:    a = 8'h61;
      3'd6:    a = 8'hc1;
      default: a = 8'he1;
    endcase
    return a;
  endfunction

  // high byte ORs into the attribute, low byte is the replacement code
  function automatic logic [15:0] special_map(input logic [4:0] code);
    logic [15:0] m;
    case (code)
      5'h01:   m = 16'h00ea;
      5'h02:   m = 16'h00ec;
      5'h03:   m = 16'h0095;
      5'h04:   m = 16'h0096;
      5'h05:   m = 16'h0098;
      5'h06:   m = 16'h0099;
      5'h07:   m = 16'h009a;
      5'h08:   m = 16'h009b;
      5'h09:   m = 16'h0095;
      5'h0a:   m = 16'h0096;
      5'h0b:   m = 16'h009c;
      5'h0c:   m = 16'h009d;
      5'h0d:   m = 16'h009e;
      5'h0e:   m = 16'h009f;
      5'h0f:   m = 16'h0483;
      5'h10:   m = 16'h0083;
      5'h11:   m = 16'h0087;
      5'h12:   m = 16'h00ea;
      5'h13:   m = 16'h00f0;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

  function automatic logic is_lead(input logic [7:0] c);
    return ((c >= LEAD_A_LO) && (c <= LEAD_A_HI)) ||
           ((c >= LEAD_B_LO) && (c <= LEAD_B_HI));
  endfunction

  // Shift JIS pair to JIS word, low byte row minus 0x20 with borrow from cell
  function automatic logic [15:0] jis_word(input logic [7:0] c1, input logic [7:0] c2);
    logic       adjust;
    logic [7:0] row_off;
    logic [7:0] cell_off;
    logic [7:0] row_base;
    logic [7:0] jrow;
    logic [7:0] jcell;
    adjust   = (c2 < 8'd159);
    row_off  = (c1 < 8'd160) ? 8'd112 : 8'd176;
    cell_off = adjust ? ((c2 > 8'd127) ? 8'd32 : 8'd31) : 8'd126;
    row_base = c1 - row_off;
    jrow     = {row_base[6:0], 1'b0} - {7'd0, adjust};
    jcell    = c2 - cell_off;
    return {jcell, 8'h00} + {8'h00, jrow} - {8'h00, BLANK_CHAR};
  endfunction

endpackage
`default_nettype wire

/* sv/text_cell_sjis_vram_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_cell_sjis_vram_encoder
// Source text cells in, text VRAM writes out, with Shift JIS to JIS pairing.
// ----------------------------------------------------------------------------
//  port group   dir  payload
//  s_axis_*     in   one source text cell per beat
//  m_axis_*     out  one VRAM write per beat
//  cfg_*        in   screen_columns, address stride
//
//  One cell enters per cycle unless a right half is pending or output stalls.
//  A single-byte cell or a lead at span end makes one write, a held lead none,
//  a trail byte two writes; during the second the input register holds.
//  Synchronous reset clears valid, held lead and right half flags and sets
//  the stride to 80. m_axis_tready low stalls both stages but for lead holds.
// ----------------------------------------------------------------------------
module text_cell_sjis_vram_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] char_byte, [15:8] color_byte, [20:16] row_index,
  // [27:21] column_index, [31:28] zero
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,   // span_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [10:0] cell_address, [26:11] char_word, [34:27] attr_byte, [39:35] zero
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast    // last_write
);

  tcsve_pkg::cell_t in_cell;
  tcsve_pkg::cell_t src_cell;
  tcsve_pkg::wr_t   wr;
  tcsve_pkg::wr_t   out_wr;
  logic             cell_valid;
  logic             consume;
  logic             emit;
  logic             slot_free;

  assign in_cell = '{char_byte: s_axis_tdata[7:0], fg: s_axis_tdata[10:8],
                     row_index: s_axis_tdata[20:16], column_index: s_axis_tdata[27:21],
                     span_end: s_axis_tlast};

  tcsve_input_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cell    (in_cell),
    .consume    (consume),
    .cell_valid (cell_valid),
    .src_cell   (src_cell)
  );

  tcsve_encode u_enc (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .cell_valid (cell_valid),
    .src_cell   (src_cell),
    .consume    (consume),
    .slot_free  (slot_free),
    .emit       (emit),
    .wr         (wr)
  );

  tcsve_output_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .wr        (wr),
    .slot_free (slot_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_wr    (out_wr)
  );

  assign m_axis_tdata = {5'd0, out_wr.attr_byte, out_wr.char_word, out_wr.cell_address};
  assign m_axis_tlast = out_wr.last_write;

endmodule
`default_nettype wire

/* sv/tcsve_input_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcsve_input_stage
// Input register for source cells; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module tcsve_input_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tcsve_pkg::cell_t in_cell,
  input  wire logic           consume,
  output logic                cell_valid,
  output tcsve_pkg::cell_t    src_cell
);

  assign in_ready = !cell_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (in_ready) begin
      cell_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      src_cell <= in_cell;
    end
  end

endmodule
`default_nettype wire

/* sv/tcsve_encode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcsve_encode
// Lead byte hold, JIS conversion, special-code remap and write generation.
// A converted pair leaves its right half in a second-half register.
// ----------------------------------------------------------------------------
module tcsve_encode (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wen,
  input  wire logic [tcsve_pkg::COLS_W-1:0] cfg_wdata,
  input  wire logic                         cell_valid,
  input  wire tcsve_pkg::cell_t             src_cell,
  output logic                              consume,
  input  wire logic                         slot_free,
  output logic                              emit,
  output tcsve_pkg::wr_t                    wr
);

  logic [tcsve_pkg::COLS_W-1:0] screen_columns;
  logic                         lead_pending;
  logic [7:0]                   held_lead_byte;
  logic [tcsve_pkg::FG_W-1:0]   held_fg_color;
  logic [tcsve_pkg::ADDR_W-1:0] held_cell_address;
  logic                         pend2;
  tcsve_pkg::wr_t               sec_wr;

  logic [tcsve_pkg::ROW_W+tcsve_pkg::COLS_W-1:0] addr_prod;
  logic [tcsve_pkg::ADDR_W-1:0] addr;
  logic [15:0]                  jword;
  logic [15:0]                  smap;
  logic                         special;
  logic [7:0]                   attr_cur;
  logic [7:0]                   attr_held;
  logic                         hold_lead;
  logic                         take_pair;

  assign addr_prod = {{tcsve_pkg::COLS_W{1'b0}}, src_cell.row_index} *
                     {{tcsve_pkg::ROW_W{1'b0}}, screen_columns};
  assign addr      = addr_prod[tcsve_pkg::ADDR_W-1:0] +
                     {{(tcsve_pkg::ADDR_W-tcsve_pkg::COLS_W){1'b0}}, src_cell.column_index};
  assign jword     = tcsve_pkg::jis_word(held_lead_byte, src_cell.char_byte);
  assign smap      = tcsve_pkg::special_map(src_cell.char_byte[4:0]);
  assign special   = src_cell.char_byte < tcsve_pkg::SPECIAL_LIMIT;
  assign attr_cur  = tcsve_pkg::fg_attr(src_cell.fg);
  assign attr_held = tcsve_pkg::fg_attr(held_fg_color);

  always_comb begin
    consume   = 1'b0;
    emit      = 1'b0;
    hold_lead = 1'b0;
    take_pair = 1'b0;
    wr        = sec_wr;
    if (pend2) begin
      emit = slot_free;
    end else if (cell_valid) begin
      if (lead_pending) begin
        take_pair = slot_free;
        consume   = slot_free;
        emit      = slot_free;
        wr        = '{cell_address: held_cell_address, char_word: jword,
                      attr_byte: attr_held, last_write: 1'b0};
      end else if (tcsve_pkg::is_lead(src_cell.char_byte) && !src_cell.span_end) begin
        hold_lead = 1'b1;
        consume   = 1'b1;
      end else begin
        consume = slot_free;
        emit    = slot_free;
        if (tcsve_pkg::is_lead(src_cell.char_byte)) begin
          wr = '{cell_address: addr, char_word: {8'h00, tcsve_pkg::BLANK_CHAR},
                 attr_byte: attr_cur, last_write: 1'b1};
        end else if (special) begin
          wr = '{cell_address: addr, char_word: {8'h00, smap[7:0]},
                 attr_byte: attr_cur | smap[15:8], last_write: 1'b1};
        end else begin
          wr = '{cell_address: addr, char_word: {8'h00, src_cell.char_byte},
                 attr_byte: attr_cur, last_write: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= tcsve_pkg::COLS_RESET;
      lead_pending   <= 1'b0;
      pend2          <= 1'b0;
    end else begin
      if (cfg_wen) begin
        screen_columns <= cfg_wdata;
      end
      if (hold_lead) begin
        lead_pending <= 1'b1;
      end else if (take_pair) begin
        lead_pending <= 1'b0;
      end
      if (take_pair) begin
        pend2 <= 1'b1;
      end else if (emit) begin
        pend2 <= 1'b0;
      end
    end
    if (hold_lead) begin
      held_lead_byte    <= src_cell.char_byte;
      held_fg_color     <= src_cell.fg;
      held_cell_address <= addr;
    end
    if (take_pair) begin
      sec_wr <= '{cell_address: held_cell_address + {{(tcsve_pkg::ADDR_W-1){1'b0}}, 1'b1},
                  char_word: jword | {8'h00, tcsve_pkg::RIGHT_HALF},
                  attr_byte: attr_held, last_write: 1'b1};
    end
  end

  // a right half waits only after a pair cleared the held lead
  a_pend2_no_lead: assert property (@(posedge clk) disable iff (rst)
    pend2 |-> !lead_pending)
    else $error("second half pending with a lead still held");

  a_pend2_origin: assert property (@(posedge clk) disable iff (rst)
    (pend2 && !$past(pend2)) |-> $past(lead_pending) && $past(cell_valid))
    else $error("second half started without a pair");

  a_pend2_drains: assert property (@(posedge clk) disable iff (rst)
    (pend2 && slot_free) |=> !pend2)
    else $error("second half not drained when slot was free");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> slot_free)
    else $error("write issued into a full output slot");

endmodule
`default_nettype wire

/* sv/tcsve_output_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcsve_output_stage
// Result register toward the VRAM write stream.
// ----------------------------------------------------------------------------
module tcsve_output_stage (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        emit,
  input  wire tcsve_pkg::wr_t wr,
  output logic             slot_free,
  output logic             out_valid,
  input  wire logic        out_ready,
  output tcsve_pkg::wr_t   out_wr
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
    if (slot_free && emit) begin
      out_wr <= wr;
    end
  end

endmodule
`default_nettype wire
